[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the upload sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[hw/rtl/cus_pkg.sv]
// Types, constants and the CRC step shared by the upload sender modules.
package cus_pkg;

  localparam int unsigned MAX_SIZE_DEF = 524288;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned Q_AW         = 2;

  localparam logic [19:0] SIZE_RST    = 20'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd4000;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_CRC_BAD  = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT  = 2'd2;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd3;

  localparam logic CFG_IDX_SIZE    = 1'b0;
  localparam logic CFG_IDX_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_RX    = 2'd1,
    FN_DATA  = 2'd2,
    FN_TICK  = 2'd3
  } func_t;

  // BYTE: one byte; STATUS: completion; WORD: 4 bytes LE;
  // DATA_END: data byte, 'C', then 4 CRC bytes LE.
  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_STATUS   = 2'd1,
    OP_WORD     = 2'd2,
    OP_DATA_END = 2'd3
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  bval;
    logic [1:0]  status;
    logic [31:0] word;
  } job_t;

  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/cus_front.sv]
// Front end: config registers, handshake state machine, CRC, job generation.
`include "assert_macros.svh"

module cus_front import cus_pkg::*; #(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic       in_push,
  input  logic [1:0] in_func,
  input  logic [7:0] in_byte_value,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_WAIT_A = 6'b000010,
    PH_WAIT_B = 6'b000100,
    PH_STREAM = 6'b001000,
    PH_WAIT_C = 6'b010000,
    PH_RECV   = 6'b100000
  } phase_t;

  logic [19:0] size_r;
  logic [15:0] timeout_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [19:0] bytes_r, bytes_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [1:0]  rcnt_r, rcnt_nxt;

  logic        accept;
  logic        size_bad;
  logic [20:0] bytes_inc;
  logic        stream_end;
  logic [31:0] crc_fold;
  logic [31:0] rcrc_new;
  logic [16:0] tick_next;

  assign accept     = in_push && !q_full;
  assign size_bad   = (size_r == 20'd0) || ({12'd0, size_r} > 32'(MAX_SIZE));
  assign bytes_inc  = {1'b0, bytes_r} + 21'd1;
  assign stream_end = bytes_inc >= {1'b0, size_r};
  assign crc_fold   = crc32_fold(crc_r, in_byte_value);
  assign rcrc_new   = rcrc_r | ({24'd0, in_byte_value} << {rcnt_r, 3'b000});
  assign tick_next  = {1'b0, elapsed_r} + 17'd1;

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    bytes_nxt   = bytes_r;
    elapsed_nxt = elapsed_r;
    rcrc_nxt    = rcrc_r;
    rcnt_nxt    = rcnt_r;
    q_push      = 1'b0;
    q_job.op     = OP_BYTE;
    q_job.bval   = in_byte_value;
    q_job.status = STAT_OK;
    q_job.word   = 32'd0;
    if (accept) begin
      case (in_func)
        FN_START: begin
          q_push = 1'b1;
          if (size_bad) begin
            q_job.op     = OP_STATUS;
            q_job.status = STAT_BAD_SIZE;
            phase_nxt    = PH_IDLE;
          end else begin
            crc_nxt     = CRC_INIT;
            bytes_nxt   = 20'd0;
            elapsed_nxt = 16'd0;
            rcrc_nxt    = 32'd0;
            rcnt_nxt    = 2'd0;
            q_job.bval  = CH_R;
            phase_nxt   = PH_WAIT_A;
          end
        end
        FN_RX: begin
          case (phase_r)
            PH_WAIT_A: begin
              if (in_byte_value == CH_A) begin
                q_push      = 1'b1;
                q_job.op    = OP_WORD;
                q_job.word  = {12'd0, size_r};
                elapsed_nxt = 16'd0;
                phase_nxt   = PH_WAIT_B;
              end
            end
            PH_WAIT_B: begin
              if (in_byte_value == CH_B) begin
                elapsed_nxt = 16'd0;
                bytes_nxt   = 20'd0;
                phase_nxt   = PH_STREAM;
              end
            end
            PH_WAIT_C: begin
              if (in_byte_value == CH_C) begin
                elapsed_nxt = 16'd0;
                rcrc_nxt    = 32'd0;
                rcnt_nxt    = 2'd0;
                phase_nxt   = PH_RECV;
              end
            end
            PH_RECV: begin
              rcrc_nxt = rcrc_new;
              if (rcnt_r == 2'd3) begin
                rcnt_nxt     = 2'd0;
                q_push       = 1'b1;
                q_job.op     = OP_STATUS;
                q_job.status = (rcrc_new == ~crc_r) ? STAT_OK : STAT_CRC_BAD;
                phase_nxt    = PH_IDLE;
              end else begin
                rcnt_nxt = rcnt_r + 2'd1;
              end
            end
            default: ;
          endcase
        end
        FN_DATA: begin
          if (phase_r == PH_STREAM) begin
            q_push    = 1'b1;
            crc_nxt   = crc_fold;
            bytes_nxt = bytes_inc[19:0];
            if (stream_end) begin
              q_job.op    = OP_DATA_END;
              q_job.word  = ~crc_fold;
              elapsed_nxt = 16'd0;
              phase_nxt   = PH_WAIT_C;
            end
          end
        end
        FN_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_next > {1'b0, timeout_r}) begin
              q_push       = 1'b1;
              q_job.op     = OP_STATUS;
              q_job.status = STAT_TIMEOUT;
              phase_nxt    = PH_IDLE;
            end else begin
              elapsed_nxt = tick_next[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_RST;
      timeout_r <= TIMEOUT_RST;
      phase_r   <= PH_IDLE;
      crc_r     <= CRC_INIT;
      bytes_r   <= 20'd0;
      elapsed_r <= 16'd0;
      rcrc_r    <= 32'd0;
      rcnt_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_SIZE:    size_r    <= cfg_wdata;
          CFG_IDX_TIMEOUT: timeout_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      bytes_r   <= bytes_nxt;
      elapsed_r <= elapsed_nxt;
      rcrc_r    <= rcrc_nxt;
      rcnt_r    <= rcnt_nxt;
    end
  end

  `ASSERT_AT(a_push_on_accept, clk, rst_n, q_push |-> (in_push && !q_full), "job push without request")
  `ASSERT_AT(a_status_idle, clk, rst_n, (q_push && q_job.op == OP_STATUS) |=> (phase_r == PH_IDLE), "not idle after status")

endmodule

[hw/rtl/cus_queue.sv]
// Short job queue between front and back end.
`include "assert_macros.svh"

module cus_queue import cus_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full  = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty, "pop from empty queue")

endmodule

[hw/rtl/cus_back.sv]
// Back end: expands queued jobs into result bytes and holds the output register.
`include "assert_macros.svh"

module cus_back import cus_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_tx_byte,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic       kind_r;
  logic [7:0] tx_r;
  logic [1:0] status_r;
  logic       last_r;

  logic [2:0] job_len;
  logic       res_last;
  logic       load;
  logic [2:0] wsel_full;
  logic [1:0] wsel;
  logic [7:0] wbyte;
  logic [7:0] res_byte;
  logic       res_kind;

  always_comb begin
    case (q_head.op)
      OP_WORD:     job_len = 3'd4;
      OP_DATA_END: job_len = 3'd6;
      default:     job_len = 3'd1;
    endcase
  end

  assign res_last  = idx_r == (job_len - 3'd1);
  assign load      = !q_empty && (!valid_r || out_pop);
  assign q_pop     = load && res_last;
  assign res_kind  = q_head.op == OP_STATUS;
  assign wsel_full = (q_head.op == OP_DATA_END) ? (idx_r - 3'd2) : idx_r;
  assign wsel      = wsel_full[1:0];
  assign wbyte     = q_head.word[{wsel, 3'b000} +: 8];

  always_comb begin
    case (q_head.op)
      OP_BYTE:     res_byte = q_head.bval;
      OP_WORD:     res_byte = wbyte;
      OP_DATA_END: begin
        if (idx_r == 3'd0) begin
          res_byte = q_head.bval;
        end else if (idx_r == 3'd1) begin
          res_byte = CH_C;
        end else begin
          res_byte = wbyte;
        end
      end
      default:     res_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= res_kind;
      tx_r     <= res_byte;
      status_r <= res_kind ? q_head.status : STAT_OK;
      last_r   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= res_last ? 3'd0 : idx_r + 3'd1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_empty   = !valid_r;
  assign out_kind    = kind_r;
  assign out_tx_byte = tx_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

  `ASSERT_NEVER(a_idx_idle, clk, rst_n, q_empty && idx_r != 3'd0, "job index moved with no job")
  `ASSERT_NEVER(a_idx_range, clk, rst_n, !q_empty && idx_r >= job_len, "job index past job length")

endmodule

[hw/rtl/crc_checked_upload_sender.sv]
// Top level of the CRC checked upload sender.
//
//  channel | ports                                     | request taken when
//  --------+-------------------------------------------+------------------------
//  input   | in_push in_full in_func in_byte_value     | in_push && !in_full
//  result  | out_pop out_empty out_kind out_tx_byte    | out_pop && !out_empty
//          | out_status out_last                       |
//  config  | cfg_we cfg_index cfg_wdata                | cfg_we
//
//  The front end takes one input request per cycle while its 4-entry job queue has room.
//  The back end emits one result per cycle while out_pop takes them; a request makes up to 6
//  results, so the output register and job expansion set the sustained rate.
//  Reset is synchronous; no clearing pass.
//  in_full rises when the job queue holds 4 jobs: results are held off, or requests that
//  make several results come faster than one result per cycle drains them.
module crc_checked_upload_sender import cus_pkg::*; #(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_byte_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic q_push;
  job_t q_job;
  logic q_full;
  logic q_pop;
  job_t q_head;
  logic q_empty;

  assign in_full = q_full;

  cus_front #(
    .MAX_SIZE(MAX_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_func      (in_func),
    .in_byte_value(in_byte_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  cus_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  cus_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_kind   (out_kind),
    .out_tx_byte(out_tx_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

[bench/crc_checked_upload_sender_tb.sv]
// Self-checking testbench for the CRC checked upload sender: directed table, then random requests.
`timescale 1ns / 100ps

module crc_checked_upload_sender_tb;
  import cus_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned RANDOM_ITEMS = 310;
  localparam int unsigned CALM_TAIL    = 270;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT_A,
    S_WAIT_B,
    S_STREAM,
    S_WAIT_C,
    S_RECV
  } link_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } upload_result_t;

  typedef struct packed {
    bit             is_reg;
    logic           reg_idx;
    func_t          fn;
    logic [19:0]    val;
    bit             typed;
    bit             echo;
    upload_result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [19:0] cfg_wdata;
  logic       in_push;
  logic       in_full;
  logic [1:0] in_func;
  logic [7:0] in_byte_value;
  logic       out_empty;
  logic       out_pop;
  logic       out_kind;
  logic [7:0] out_tx_byte;
  logic [1:0] out_status;
  logic       out_last;

  // sender model state
  logic [19:0] size_reg;
  logic [15:0] timeout_reg;
  link_phase_t phase_q;
  logic [31:0] crc_acc;
  logic [19:0] sent_cnt;
  logic [15:0] tick_cnt;
  logic [31:0] peer_crc;
  logic [1:0]  peer_cnt;

  upload_result_t step_out[$];
  upload_result_t due_results[$];
  upload_result_t head;
  upload_result_t typed_want;
  bit             use_typed = 1'b0;

  bit          calm = 1'b0;
  bit          no_idle = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned requests_done = 0;
  int unsigned mismatches = 0;

  crc_checked_upload_sender u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_byte_value (in_byte_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  function automatic void emit_result(logic kind, logic [7:0] tx, logic [1:0] st);
    upload_result_t r;
    r.kind    = kind;
    r.tx_byte = kind ? 8'h00 : tx;
    r.status  = kind ? st : STAT_OK;
    r.last    = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void emit_le_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) emit_result(1'b0, w[8*i +: 8], STAT_OK);
  endfunction

  function automatic logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  function automatic void finish_transfer(logic [1:0] st);
    emit_result(1'b1, 8'h00, st);
    phase_q = S_IDLE;
  endfunction

  function automatic logic [7:0] crc_echo_byte();
    logic [31:0] w;
    w = ~crc_acc;
    return w[8*peer_cnt +: 8];
  endfunction

  // One request through the sender: updates state, leaves its results in step_out.
  function automatic void predict_sender_step(func_t fn, logic [7:0] b);
    upload_result_t r;
    step_out.delete();
    case (fn)
      FN_START: begin
        if (size_reg == 20'd0 || size_reg > MAX_SIZE_DEF) begin
          finish_transfer(STAT_BAD_SIZE);
        end else begin
          crc_acc  = CRC_INIT;
          sent_cnt = '0;
          tick_cnt = '0;
          peer_crc = '0;
          peer_cnt = '0;
          emit_result(1'b0, CH_R, STAT_OK);
          phase_q = S_WAIT_A;
        end
      end
      FN_RX: begin
        case (phase_q)
          S_WAIT_A: if (b == CH_A) begin
            emit_le_word({12'h000, size_reg});
            tick_cnt = '0;
            phase_q  = S_WAIT_B;
          end
          S_WAIT_B: if (b == CH_B) begin
            tick_cnt = '0;
            sent_cnt = '0;
            phase_q  = S_STREAM;
          end
          S_WAIT_C: if (b == CH_C) begin
            tick_cnt = '0;
            peer_crc = '0;
            peer_cnt = '0;
            phase_q  = S_RECV;
          end
          S_RECV: begin
            peer_crc = peer_crc | ({24'h000000, b} << (8 * peer_cnt));
            if (peer_cnt == 2'd3) begin
              peer_cnt = '0;
              finish_transfer((peer_crc == ~crc_acc) ? STAT_OK : STAT_CRC_BAD);
            end else begin
              peer_cnt = peer_cnt + 2'd1;
            end
          end
          default: ;
        endcase
      end
      FN_DATA: if (phase_q == S_STREAM) begin
        emit_result(1'b0, b, STAT_OK);
        crc_acc = crc32_next(crc_acc, b);
        if ({1'b0, sent_cnt} + 21'd1 >= {1'b0, size_reg}) begin
          emit_result(1'b0, CH_C, STAT_OK);
          emit_le_word(~crc_acc);
          tick_cnt = '0;
          phase_q  = S_WAIT_C;
        end
        sent_cnt = sent_cnt + 20'd1;
      end
      default: if (phase_q != S_IDLE) begin
        if ({1'b0, tick_cnt} + 17'd1 > {1'b0, timeout_reg}) finish_transfer(STAT_TIMEOUT);
        else tick_cnt = tick_cnt + 16'd1;
      end
    endcase
    if (step_out.size() != 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  function automatic stim_row_t req_row(func_t fn, logic [7:0] b);
    stim_row_t r;
    r     = '0;
    r.fn  = fn;
    r.val = {12'h000, b};
    return r;
  endfunction

  function automatic stim_row_t typed_row(func_t fn, logic kind, logic [7:0] tx, logic [1:0] st);
    stim_row_t r;
    r = req_row(fn, 8'h00);
    r.typed        = 1'b1;
    r.want.kind    = kind;
    r.want.tx_byte = tx;
    r.want.status  = st;
    r.want.last    = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic idx, logic [19:0] v);
    stim_row_t r;
    r         = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.val     = v;
    return r;
  endfunction

  task automatic send_request(func_t fn, logic [7:0] b);
    if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push       <= 1'b1;
    in_func       <= fn;
    in_byte_value <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    requests_done++;
    predict_sender_step(fn, b);
    if (use_typed) begin
      due_results.push_back(typed_want);
      use_typed = 1'b0;
    end else begin
      foreach (step_out[i]) due_results.push_back(step_out[i]);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_IDX_SIZE) size_reg = val;
    else timeout_reg = val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly the request the current phase waits for, with ticks, noise and abandons mixed in.
  task automatic drive_transfer(bit fresh);
    int unsigned steps;
    int unsigned pick;
    logic [7:0]  b;
    steps = 0;
    if (fresh) begin
      send_request(FN_START, 8'($urandom));
    end
    while (phase_q != S_IDLE && steps < 40 && requests_done < RANDOM_ITEMS) begin
      steps++;
      pick = $urandom_range(0, 59);
      if (pick == 0) begin
        return;
      end else if (pick < 10) begin
        send_request(FN_TICK, 8'($urandom));
      end else if (pick < 15) begin
        send_request(func_t'($urandom_range(1, 3)), 8'($urandom));
      end else begin
        case (phase_q)
          S_WAIT_A: b = CH_A;
          S_WAIT_B: b = CH_B;
          S_WAIT_C: b = CH_C;
          S_RECV:   b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : crc_echo_byte();
          default:  b = 8'($urandom);
        endcase
        send_request((phase_q == S_STREAM) ? FN_DATA : FN_RX, b);
      end
    end
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: result with none due, expected nothing, got kind %0d tx %0h st %0d last %0d",
                 $time, out_kind, out_tx_byte, out_status, out_last);
        mismatches++;
      end else begin
        head = due_results.pop_front();
        check_field("kind", {7'd0, head.kind}, {7'd0, out_kind});
        check_field("tx_byte", head.tx_byte, out_tx_byte);
        check_field("status", {6'd0, head.status}, {6'd0, out_status});
        check_field("last", {7'd0, head.last}, {7'd0, out_last});
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #400_000;
    $display("[crc_checked_upload_sender] ERROR");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    stim_row_t   r;
    logic [7:0]  b;
    logic [19:0] size_pick;
    logic [15:0] timeout_pick;
    bit          backlog_done;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IDX_SIZE;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_func       = FN_START;
    in_byte_value = 8'h00;
    out_pop       = 1'b0;
    backlog_done  = 1'b0;

    size_reg    = SIZE_RST;
    timeout_reg = TIMEOUT_RST;
    phase_q     = S_IDLE;
    crc_acc     = CRC_INIT;
    sent_cnt    = '0;
    tick_cnt    = '0;
    peer_crc    = '0;
    peer_cnt    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // size is zero out of reset
    rows.push_back(typed_row(FN_START, 1'b1, 8'h00, STAT_BAD_SIZE));
    rows.push_back(req_row(FN_TICK, 8'hFF));
    rows.push_back(req_row(FN_RX, CH_A));
    rows.push_back(req_row(FN_DATA, 8'h5A));
    rows.push_back(reg_row(CFG_IDX_SIZE, 20'(MAX_SIZE_DEF)));
    rows.push_back(reg_row(CFG_IDX_TIMEOUT, 20'd1));
    rows.push_back(typed_row(FN_START, 1'b0, CH_R, STAT_OK));
    rows.push_back(req_row(FN_RX, CH_A));
    rows.push_back(req_row(FN_TICK, 8'h00));
    rows.push_back(typed_row(FN_TICK, 1'b1, 8'h00, STAT_TIMEOUT));
    rows.push_back(reg_row(CFG_IDX_SIZE, 20'd3));
    rows.push_back(reg_row(CFG_IDX_TIMEOUT, 20'h0FFFF));
    rows.push_back(typed_row(FN_START, 1'b0, CH_R, STAT_OK));
    rows.push_back(req_row(FN_RX, 8'hFF));
    rows.push_back(req_row(FN_RX, CH_A));
    rows.push_back(req_row(FN_RX, CH_A));
    rows.push_back(req_row(FN_DATA, 8'h00));
    rows.push_back(req_row(FN_RX, CH_B));
    rows.push_back(req_row(FN_RX, 8'h7E));
    rows.push_back(req_row(FN_DATA, 8'h00));
    rows.push_back(req_row(FN_DATA, 8'hFF));
    rows.push_back(req_row(FN_DATA, 8'hA5));
    rows.push_back(req_row(FN_RX, 8'h00));
    rows.push_back(req_row(FN_RX, CH_C));
    repeat (4) begin
      r = req_row(FN_RX, 8'h00);
      r.echo = 1'b1;
      rows.push_back(r);
    end

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].val);
      end else begin
        b = rows[i].echo ? crc_echo_byte() : rows[i].val[7:0];
        use_typed  = rows[i].typed;
        typed_want = rows[i].want;
        send_request(rows[i].fn, b);
      end
    end

    while (requests_done < RANDOM_ITEMS) begin
      drain_results();
      no_idle = (requests_done >= CALM_TAIL);
      calm    = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0:       size_pick = 20'd0;
        1:       size_pick = 20'(MAX_SIZE_DEF);
        2, 3:    size_pick = 20'($urandom_range(13, MAX_SIZE_DEF));
        4:       size_pick = 20'd1;
        default: size_pick = 20'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       timeout_pick = 16'd1;
        1:       timeout_pick = 16'hFFFF;
        2:       timeout_pick = TIMEOUT_RST;
        default: timeout_pick = 16'($urandom_range(2, 24));
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(CFG_IDX_SIZE, size_pick);
      if ($urandom_range(0, 1) != 0) write_reg(CFG_IDX_TIMEOUT, {4'h0, timeout_pick});
      if (!backlog_done && requests_done >= 60) begin
        // restarts pile up results while the result side holds off
        backlog_done = 1'b1;
        write_reg(CFG_IDX_SIZE, 20'd5);
        rx_hold_req = 1'b1;
        repeat (16) begin
          send_request(FN_START, 8'($urandom));
        end
      end
      if (phase_q != S_IDLE) drive_transfer(1'b0);
      repeat ($urandom_range(1, 3)) drive_transfer(1'b1);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("[crc_checked_upload_sender] OK");
    end else begin
      $display("[crc_checked_upload_sender] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cus_pkg.sv
hw/rtl/cus_front.sv
hw/rtl/cus_queue.sv
hw/rtl/cus_back.sv
hw/rtl/crc_checked_upload_sender.sv
bench/crc_checked_upload_sender_tb.sv
